// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define PIG_ASSERT(lbl, ck, rn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define PIG_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) (prop)) else $error(msg);

`endif

// ===== hdl/pig_pkg.sv =====
// Types and constants of the packet inter-arrival grouper.
`default_nettype none
package pig_pkg;

  typedef enum logic [1:0] {
    ST_ACCEPTED     = 2'd0,
    ST_OUT_OF_ORDER = 2'd1,
    ST_RESET        = 2'd2,
    ST_REORDER      = 2'd3
  } status_t;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_BURST_EN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_THR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_THR = 2'd3;

  localparam logic        BURST_EN_RST   = 1'b1;
  localparam logic [31:0] GROUP_LEN_RST  = 32'd450;
  localparam logic [7:0]  BURST_THR_RST  = 8'd5;
  localparam logic [15:0] OFFSET_THR_RST = 16'd3000;

  localparam logic [2:0]  REORDER_LIMIT = 3'd3;
  localparam logic [2:0]  REORDER_MAX   = 3'd7;
  localparam logic [23:0] BYTES_MAX     = 24'hFF_FFFF;
  localparam logic [47:0] S48_MAX       = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] S48_MIN       = 48'h8000_0000_0000;

endpackage
`default_nettype wire

// ===== hdl/pig_in_if.sv =====
// Packet channel into the grouper.
`default_nettype none
interface pig_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] send_ticks;
  logic [47:0] arrival_ms;
  logic [47:0] local_ms;
  logic [15:0] payload_bytes;

  modport source (output valid, send_ticks, arrival_ms, local_ms, payload_bytes,
                  input ready);
  modport sink   (input valid, send_ticks, arrival_ms, local_ms, payload_bytes,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/pig_out_if.sv =====
// Result channel out of the grouper.
`default_nettype none
interface pig_out_if
  import pig_pkg::*;
;
  logic               valid;
  logic               ready;
  logic               deltas_valid;
  status_t            status;
  logic        [31:0] send_delta_ticks;
  logic signed [47:0] arrival_delta_ms;
  logic signed [24:0] size_delta_bytes;

  modport source (output valid, deltas_valid, status, send_delta_ticks,
                  arrival_delta_ms, size_delta_bytes, input ready);
  modport sink   (input valid, deltas_valid, status, send_delta_ticks,
                  arrival_delta_ms, size_delta_bytes, output ready);
endinterface
`default_nettype wire

// ===== hdl/packet_interarrival_grouper.sv =====
// Packet inter-arrival grouper: groups packets by send time and reports group deltas.
// Path: an accepted packet beat goes into the input register; its result is offered
// from the result register. Throughput: one packet per cycle while results are taken;
// the group state is updated from the input register, so packets can go back to back.
// Reset (synchronous, rst_n low) empties both groups, clears the reorder count,
// loads the default configuration and drops any packet in flight.
`default_nettype none
module packet_interarrival_grouper
  import pig_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  pig_in_if.sink                     in_pkt,
  pig_out_if.source                  out_res
);

  // Configuration.
  logic        burst_en_r;
  logic [31:0] group_len_r;
  logic [7:0]  burst_thr_r;
  logic [15:0] offset_thr_r;

  // Input register.
  logic        s1_valid_r;
  logic [31:0] s1_send_r;
  logic [47:0] s1_arr_r;
  logic [47:0] s1_loc_r;
  logic [15:0] s1_pay_r;

  // Group state.
  logic        cur_has_r, cur_has_nxt;
  logic [31:0] cur_first_r, cur_first_nxt;
  logic [31:0] cur_last_r, cur_last_nxt;
  logic [47:0] cur_arr_r, cur_arr_nxt;
  logic [47:0] cur_loc_r, cur_loc_nxt;
  logic [23:0] cur_bytes_r, cur_bytes_nxt;
  logic        prev_has_r, prev_has_nxt;
  logic [31:0] prev_last_r, prev_last_nxt;
  logic [47:0] prev_arr_r, prev_arr_nxt;
  logic [47:0] prev_loc_r, prev_loc_nxt;
  logic [23:0] prev_bytes_r, prev_bytes_nxt;
  logic [2:0]  reorder_cnt_r, reorder_cnt_nxt;

  // Result register.
  logic               out_valid_r;
  logic               dvalid_r, dvalid_nxt;
  status_t            status_r, status_nxt;
  logic        [31:0] d_send_r, d_send_nxt;
  logic        [47:0] d_arr_r, d_arr_nxt;
  logic        [24:0] d_size_r, d_size_nxt;

  logic advance;
  logic fire;

  // Decision terms.
  logic        older;
  logic [48:0] arr_gap;
  logic [31:0] tick_gap;
  logic [49:0] gap_diff;
  logic        is_burst;
  logic [31:0] span;
  logic        new_group;
  logic [48:0] grp_a;
  logic [48:0] grp_s;
  logic [49:0] s_plus_thr;
  logic        offset_jump;
  logic [47:0] a_sat;
  logic [2:0]  cnt_inc;
  logic [23:0] bytes_base;
  logic [24:0] bytes_sum;
  logic        take_pkt;

  assign advance      = !out_valid_r || out_res.ready;
  assign fire         = s1_valid_r && advance;
  assign in_pkt.ready = !s1_valid_r || advance;

  always_comb begin
    older    = s1_send_r < cur_first_r;
    arr_gap  = {1'b0, s1_arr_r} - {1'b0, cur_arr_r};
    tick_gap = s1_send_r - cur_last_r;
    gap_diff = {arr_gap[48], arr_gap} - {18'd0, tick_gap};
    is_burst = burst_en_r && ((tick_gap == 32'd0) ||
               (gap_diff[49] && ($signed(arr_gap) <= $signed({41'd0, burst_thr_r}))));
    span      = s1_send_r - cur_first_r;
    new_group = !is_burst && (span > group_len_r);

    grp_a       = {1'b0, cur_arr_r} - {1'b0, prev_arr_r};
    grp_s       = {1'b0, cur_loc_r} - {1'b0, prev_loc_r};
    s_plus_thr  = {grp_s[48], grp_s} + {34'd0, offset_thr_r};
    offset_jump = $signed({grp_a[48], grp_a}) > $signed(s_plus_thr);
    if (grp_a[48] != grp_a[47]) begin
      a_sat = grp_a[48] ? S48_MIN : S48_MAX;
    end else begin
      a_sat = grp_a[47:0];
    end
    cnt_inc = (reorder_cnt_r < REORDER_MAX) ? reorder_cnt_r + 3'd1 : reorder_cnt_r;
  end

  always_comb begin
    cur_has_nxt     = cur_has_r;
    cur_first_nxt   = cur_first_r;
    cur_last_nxt    = cur_last_r;
    cur_arr_nxt     = cur_arr_r;
    cur_loc_nxt     = cur_loc_r;
    cur_bytes_nxt   = cur_bytes_r;
    prev_has_nxt    = prev_has_r;
    prev_last_nxt   = prev_last_r;
    prev_arr_nxt    = prev_arr_r;
    prev_loc_nxt    = prev_loc_r;
    prev_bytes_nxt  = prev_bytes_r;
    reorder_cnt_nxt = reorder_cnt_r;
    dvalid_nxt      = 1'b0;
    status_nxt      = ST_ACCEPTED;
    d_send_nxt      = '0;
    d_arr_nxt       = '0;
    d_size_nxt      = '0;
    take_pkt        = 1'b0;
    // An empty group counts as zero bytes whatever the byte register holds.
    bytes_base      = cur_has_r ? cur_bytes_r : 24'd0;

    priority if (!cur_has_r) begin
      cur_first_nxt = s1_send_r;
      cur_last_nxt  = s1_send_r;
      take_pkt      = 1'b1;
    end else if (older) begin
      status_nxt = ST_OUT_OF_ORDER;
    end else if (new_group) begin
      priority if (prev_has_r && offset_jump) begin
        cur_has_nxt     = 1'b0;
        prev_has_nxt    = 1'b0;
        reorder_cnt_nxt = '0;
        status_nxt      = ST_RESET;
      end else if (prev_has_r && grp_a[48]) begin
        reorder_cnt_nxt = cnt_inc;
        if (cnt_inc > REORDER_LIMIT) begin
          cur_has_nxt     = 1'b0;
          prev_has_nxt    = 1'b0;
          reorder_cnt_nxt = '0;
        end
        status_nxt = ST_REORDER;
      end else begin
        if (prev_has_r) begin
          reorder_cnt_nxt = '0;
          dvalid_nxt      = 1'b1;
          d_send_nxt      = cur_last_r - prev_last_r;
          d_arr_nxt       = a_sat;
          d_size_nxt      = {1'b0, cur_bytes_r} - {1'b0, prev_bytes_r};
        end
        // The finished group becomes the previous one and this packet opens a new one.
        prev_has_nxt   = 1'b1;
        prev_last_nxt  = cur_last_r;
        prev_arr_nxt   = cur_arr_r;
        prev_loc_nxt   = cur_loc_r;
        prev_bytes_nxt = cur_bytes_r;
        cur_first_nxt  = s1_send_r;
        cur_last_nxt   = s1_send_r;
        bytes_base     = 24'd0;
        take_pkt       = 1'b1;
      end
    end else begin
      if (s1_send_r > cur_last_r) begin
        cur_last_nxt = s1_send_r;
      end
      take_pkt = 1'b1;
    end

    bytes_sum = {1'b0, bytes_base} + {9'd0, s1_pay_r};
    if (take_pkt) begin
      cur_bytes_nxt = bytes_sum[24] ? BYTES_MAX : bytes_sum[23:0];
      cur_arr_nxt   = s1_arr_r;
      cur_loc_nxt   = s1_loc_r;
      cur_has_nxt   = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      burst_en_r    <= BURST_EN_RST;
      group_len_r   <= GROUP_LEN_RST;
      burst_thr_r   <= BURST_THR_RST;
      offset_thr_r  <= OFFSET_THR_RST;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      cur_has_r     <= 1'b0;
      prev_has_r    <= 1'b0;
      reorder_cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_BURST_EN:   burst_en_r   <= cfg_wdata[0];
          CFG_GROUP_LEN:  group_len_r  <= cfg_wdata[31:0];
          CFG_BURST_THR:  burst_thr_r  <= cfg_wdata[7:0];
          CFG_OFFSET_THR: offset_thr_r <= cfg_wdata[15:0];
        endcase
      end
      if (in_pkt.ready) begin
        s1_valid_r <= in_pkt.valid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (fire) begin
        cur_has_r     <= cur_has_nxt;
        prev_has_r    <= prev_has_nxt;
        reorder_cnt_r <= reorder_cnt_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_pkt.ready && in_pkt.valid) begin
      s1_send_r <= in_pkt.send_ticks;
      s1_arr_r  <= in_pkt.arrival_ms;
      s1_loc_r  <= in_pkt.local_ms;
      s1_pay_r  <= in_pkt.payload_bytes;
    end
    if (fire) begin
      cur_first_r  <= cur_first_nxt;
      cur_last_r   <= cur_last_nxt;
      cur_arr_r    <= cur_arr_nxt;
      cur_loc_r    <= cur_loc_nxt;
      cur_bytes_r  <= cur_bytes_nxt;
      prev_last_r  <= prev_last_nxt;
      prev_arr_r   <= prev_arr_nxt;
      prev_loc_r   <= prev_loc_nxt;
      prev_bytes_r <= prev_bytes_nxt;
      dvalid_r     <= dvalid_nxt;
      status_r     <= status_nxt;
      d_send_r     <= d_send_nxt;
      d_arr_r      <= d_arr_nxt;
      d_size_r     <= d_size_nxt;
    end
  end

  assign out_res.valid            = out_valid_r;
  assign out_res.deltas_valid     = dvalid_r;
  assign out_res.status           = status_r;
  assign out_res.send_delta_ticks = d_send_r;
  assign out_res.arrival_delta_ms = $signed(d_arr_r);
  assign out_res.size_delta_bytes = $signed(d_size_r);

endmodule
`default_nettype wire

// ===== hdl/pig_checker.sv =====
// Port-level checks of the grouper and the bind that attaches them.
`default_nettype none
`include "assert_macros.svh"
module pig_checker
  import pig_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        deltas_valid,
  input wire status_t     status,
  input wire logic [31:0] send_delta_ticks,
  input wire logic [47:0] arrival_delta_ms,
  input wire logic [24:0] size_delta_bytes
);

  // A result beat that is not taken stays offered.
  `PIG_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")

  // Deltas are only reported for packets that were taken into a group.
  `PIG_ASSERT(a_dvalid_status, clk, rst_n, !out_valid || !deltas_valid || status == ST_ACCEPTED, "deltas reported with a drop status")

  // Without deltas every delta field reads zero.
  `PIG_ASSERT(a_zero_deltas, clk, rst_n, !out_valid || deltas_valid || (send_delta_ticks == 32'd0 && arrival_delta_ms == 48'd0 && size_delta_bytes == 25'd0), "nonzero delta without deltas_valid")

  // Reset empties the pipeline and leaves the input open.
  `PIG_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid && in_ready, "pipeline not empty after reset")

endmodule

bind packet_interarrival_grouper pig_checker u_pig_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_pkt.ready),
  .out_valid        (out_res.valid),
  .out_ready        (out_res.ready),
  .deltas_valid     (out_res.deltas_valid),
  .status           (out_res.status),
  .send_delta_ticks (out_res.send_delta_ticks),
  .arrival_delta_ms (out_res.arrival_delta_ms),
  .size_delta_bytes (out_res.size_delta_bytes)
);
`default_nettype wire
